// ----- rtl/geomip_fan_index_generator_top_macros.svh -----
// Assertion macros shared by the fan index generator.
`ifndef GEOMIP_FAN_INDEX_GENERATOR_TOP_MACROS_SVH
`define GEOMIP_FAN_INDEX_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GFIG_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("gfig assertion failed");

// Next-cycle implication, checked outside reset.
`define GFIG_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("gfig assertion failed");

`endif

// ----- rtl/gfig_pkg.sv -----
package gfig_pkg;

    // Largest supported terrain side, sets the width of the length register.
    localparam int MAX_TERRAIN_LENGTH = 4097;
    localparam int TL_W               = $clog2(MAX_TERRAIN_LENGTH);
    localparam logic [TL_W-1:0] TERRAIN_LENGTH_RESET = TL_W'(257);

    // Field widths.
    localparam int SLOT_W = 24;
    localparam int LOD_W  = 4;
    localparam int XZ_W   = 13;
    localparam int IDX_W  = 25;

    // Internal arithmetic widths.
    localparam int PROD_W = 2 * TL_W;    // z * t and t * t
    localparam int BASE_W = PROD_W + 1;  // z * t + x
    localparam int CEN_W  = 30;          // centre index before truncation
    localparam int WALK_W = 34;          // signed rim walk, covers eight steps

    // Sides in walk order.
    localparam logic [1:0] SIDE_LEFT   = 2'd0;
    localparam logic [1:0] SIDE_TOP    = 2'd1;
    localparam logic [1:0] SIDE_RIGHT  = 2'd2;
    localparam logic [1:0] SIDE_BOTTOM = 2'd3;

    // Triangle slots are three entries apart.
    localparam logic [SLOT_W-1:0] SLOT_STEP = SLOT_W'(3);

endpackage

// ----- rtl/gfig_fan_if.sv -----
// Fan description channel.
interface gfig_fan_if;
    logic                            valid;
    logic                            ready;
    logic [gfig_pkg::SLOT_W-1:0]     buffer_offset;
    logic [gfig_pkg::LOD_W-1:0]      lod_core;
    logic [gfig_pkg::LOD_W-1:0]      lod_left;
    logic [gfig_pkg::LOD_W-1:0]      lod_right;
    logic [gfig_pkg::LOD_W-1:0]      lod_top;
    logic [gfig_pkg::LOD_W-1:0]      lod_bottom;
    logic [gfig_pkg::XZ_W-1:0]       fan_x;
    logic [gfig_pkg::XZ_W-1:0]       fan_z;

    modport source (
        output valid, buffer_offset, lod_core, lod_left, lod_right, lod_top, lod_bottom,
               fan_x, fan_z,
        input  ready
    );

    modport sink (
        input  valid, buffer_offset, lod_core, lod_left, lod_right, lod_top, lod_bottom,
               fan_x, fan_z,
        output ready
    );
endinterface

// ----- rtl/gfig_tri_if.sv -----
// Triangle result channel.
interface gfig_tri_if;
    logic                            valid;
    logic                            ready;
    logic [gfig_pkg::SLOT_W-1:0]     slot;
    logic [gfig_pkg::IDX_W-1:0]      center_index;
    logic [gfig_pkg::IDX_W-1:0]      first_index;
    logic [gfig_pkg::IDX_W-1:0]      second_index;
    logic                            out_of_range;
    logic                            last;

    modport source (
        output valid, slot, center_index, first_index, second_index, out_of_range, last,
        input  ready
    );

    modport sink (
        input  valid, slot, center_index, first_index, second_index, out_of_range, last,
        output ready
    );
endinterface

// ----- rtl/geomip_fan_index_generator_top.sv -----
// Channel    Dir  Handshake      Contents
// fan        in   valid/ready    one fan: offset, five levels, corner x and z
// triangle   out  valid/ready    one triangle: slot, three indices, range flag, last
// cfg        in   cfg_we         terrain_length write, taken on any rising edge with cfg_we high
//
// A fan passes two arithmetic stages (multiply, then sums and side steps) and
// reaches the emitter, which sends one triangle per cycle, while triangle is not
// stalled, from its rim adder into the output register. A fan of 4 to 8 triangles
// occupies the emitter until its last one leaves, and the next fan is loaded in the
// cycle its predecessor's last triangle leaves. Reset clears all valid bits and
// sets terrain_length to 257. A stall on triangle holds every occupied stage.
`include "geomip_fan_index_generator_top_macros.svh"

module geomip_fan_index_generator_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [gfig_pkg::TL_W-1:0]  cfg_wdata,
    gfig_fan_if.sink                   fan,
    gfig_tri_if.source                 triangle
);

    localparam int TL_W   = gfig_pkg::TL_W;
    localparam int SLOT_W = gfig_pkg::SLOT_W;
    localparam int LOD_W  = gfig_pkg::LOD_W;
    localparam int XZ_W   = gfig_pkg::XZ_W;
    localparam int IDX_W  = gfig_pkg::IDX_W;
    localparam int PROD_W = gfig_pkg::PROD_W;
    localparam int BASE_W = gfig_pkg::BASE_W;
    localparam int CEN_W  = gfig_pkg::CEN_W;
    localparam int WALK_W = gfig_pkg::WALK_W;

    // Configuration register.
    logic [TL_W-1:0] tlen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlen_reg <= gfig_pkg::TERRAIN_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            tlen_reg <= cfg_wdata;
        end
    end

    // Flow control, from the output back to the input.
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic em_valid_reg;
    logic out_valid_reg;
    logic adv;
    logic tri_last;
    logic em_free;
    logic em_take;
    logic s2_adv;
    logic s1_adv;

    assign adv     = !out_valid_reg || triangle.ready;
    assign em_free = !em_valid_reg || (adv && tri_last);
    assign em_take = s2_valid_reg && em_free;
    assign s2_adv  = !s2_valid_reg || em_free;
    assign s1_adv  = !s1_valid_reg || s2_adv;
    assign fan.ready = s1_adv;

    // Stage 1: register the fan and form the two products.
    logic [SLOT_W-1:0] s1_offset_reg;
    logic [LOD_W-1:0]  s1_core_reg;
    logic [LOD_W-1:0]  s1_lod_reg [4];
    logic [XZ_W-1:0]   s1_x_reg;
    logic [TL_W-1:0]   s1_t_reg;
    logic [PROD_W-1:0] s1_zt_reg;
    logic [PROD_W-1:0] s1_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= fan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && fan.valid)
        begin
            s1_offset_reg                     <= fan.buffer_offset;
            s1_core_reg                       <= fan.lod_core;
            s1_lod_reg[gfig_pkg::SIDE_LEFT]   <= fan.lod_left;
            s1_lod_reg[gfig_pkg::SIDE_TOP]    <= fan.lod_top;
            s1_lod_reg[gfig_pkg::SIDE_RIGHT]  <= fan.lod_right;
            s1_lod_reg[gfig_pkg::SIDE_BOTTOM] <= fan.lod_bottom;
            s1_x_reg                          <= fan.fan_x;
            s1_t_reg                          <= tlen_reg;
            s1_zt_reg                         <= PROD_W'(fan.fan_z) * PROD_W'(tlen_reg);
            s1_limit_reg                      <= PROD_W'(tlen_reg) * PROD_W'(tlen_reg);
        end
    end

    // Stage 2: start vertex, centre vertex and the four signed side steps.
    logic [BASE_W-1:0]        base_next;
    logic [CEN_W-1:0]         cen_next;
    logic signed [WALK_W-1:0] delta_next [4];
    logic [3:0]               dbl_next;

    always_comb
    begin
        logic [CEN_W-1:0]  sct;
        logic [CEN_W-1:0]  sc;
        logic [WALK_W-1:0] mag;
        sct       = CEN_W'(s1_t_reg) << s1_core_reg;
        sc        = CEN_W'(1) << s1_core_reg;
        cen_next  = CEN_W'(s1_zt_reg) + sct + CEN_W'(s1_x_reg) + sc;
        base_next = BASE_W'(s1_zt_reg) + BASE_W'(s1_x_reg);
        for (int i = 0; i < 4; i++)
        begin
            mag = WALK_W'(s1_t_reg);
            if (i == int'(gfig_pkg::SIDE_LEFT) || i == int'(gfig_pkg::SIDE_RIGHT))
            begin
                mag = mag << s1_lod_reg[i];
            end
            else
            begin
                mag = WALK_W'(1) << s1_lod_reg[i];
            end
            // Left and top walk forward, right and bottom walk back.
            if (i == int'(gfig_pkg::SIDE_LEFT) || i == int'(gfig_pkg::SIDE_TOP))
            begin
                delta_next[i] = $signed(mag);
            end
            else
            begin
                delta_next[i] = -$signed(mag);
            end
            dbl_next[i] = (s1_lod_reg[i] == s1_core_reg);
        end
    end

    logic [SLOT_W-1:0]        s2_offset_reg;
    logic [BASE_W-1:0]        s2_base_reg;
    logic                     s2_base_oor_reg;
    logic [CEN_W-1:0]         s2_cen_reg;
    logic                     s2_cen_oor_reg;
    logic signed [WALK_W-1:0] s2_delta_reg [4];
    logic [3:0]               s2_dbl_reg;
    logic [PROD_W-1:0]        s2_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s1_valid_reg)
        begin
            s2_offset_reg   <= s1_offset_reg;
            s2_base_reg     <= base_next;
            s2_base_oor_reg <= (base_next >= BASE_W'(s1_limit_reg));
            s2_cen_reg      <= cen_next;
            s2_cen_oor_reg  <= (cen_next >= CEN_W'(s1_limit_reg));
            s2_delta_reg    <= delta_next;
            s2_dbl_reg      <= dbl_next;
            s2_limit_reg    <= s1_limit_reg;
        end
    end

    // Stage 3: emitter walks the rim one triangle per cycle while the output is not stalled.
    logic [1:0]               side_reg;
    logic                     rep_reg;
    logic signed [WALK_W-1:0] b_reg;
    logic                     b_oor_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [CEN_W-1:0]         em_cen_reg;
    logic                     em_cen_oor_reg;
    logic signed [WALK_W-1:0] em_delta_reg [4];
    logic [3:0]               em_dbl_reg;
    logic [PROD_W-1:0]        em_limit_reg;

    logic signed [WALK_W-1:0] limit_ext;
    logic signed [WALK_W-1:0] next_b;
    logic                     nb_oor;
    logic                     side_done;
    logic                     em_fire;

    assign limit_ext = $signed({{(WALK_W - PROD_W){1'b0}}, em_limit_reg});
    assign next_b    = b_reg + em_delta_reg[side_reg];
    assign nb_oor    = next_b[WALK_W-1] || (next_b >= limit_ext);
    assign side_done = rep_reg || !em_dbl_reg[side_reg];
    assign tri_last  = (side_reg == gfig_pkg::SIDE_BOTTOM) && side_done;
    assign em_fire   = em_valid_reg && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg <= 1'b0;
            side_reg     <= gfig_pkg::SIDE_LEFT;
            rep_reg      <= 1'b0;
        end
        else if (em_take)
        begin
            em_valid_reg <= 1'b1;
            side_reg     <= gfig_pkg::SIDE_LEFT;
            rep_reg      <= 1'b0;
        end
        else if (em_fire)
        begin
            if (tri_last)
            begin
                em_valid_reg <= 1'b0;
            end
            if (side_done)
            begin
                side_reg <= side_reg + 2'd1;
                rep_reg  <= 1'b0;
            end
            else
            begin
                rep_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (em_take)
        begin
            b_reg          <= $signed(WALK_W'(s2_base_reg));
            b_oor_reg      <= s2_base_oor_reg;
            slot_reg       <= s2_offset_reg;
            em_cen_reg     <= s2_cen_reg;
            em_cen_oor_reg <= s2_cen_oor_reg;
            em_delta_reg   <= s2_delta_reg;
            em_dbl_reg     <= s2_dbl_reg;
            em_limit_reg   <= s2_limit_reg;
        end
        else if (em_fire)
        begin
            b_reg     <= next_b;
            b_oor_reg <= nb_oor;
            slot_reg  <= slot_reg + gfig_pkg::SLOT_STEP;
        end
    end

    // Output register.
    logic [SLOT_W-1:0] out_slot_reg;
    logic [IDX_W-1:0]  out_center_reg;
    logic [IDX_W-1:0]  out_first_reg;
    logic [IDX_W-1:0]  out_second_reg;
    logic              out_oor_reg;
    logic              out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= em_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (em_fire)
        begin
            out_slot_reg   <= slot_reg;
            out_center_reg <= em_cen_reg[IDX_W-1:0];
            out_first_reg  <= b_reg[IDX_W-1:0];
            out_second_reg <= next_b[IDX_W-1:0];
            out_oor_reg    <= em_cen_oor_reg || b_oor_reg || nb_oor;
            out_last_reg   <= tri_last;
        end
    end

    assign triangle.valid        = out_valid_reg;
    assign triangle.slot         = out_slot_reg;
    assign triangle.center_index = out_center_reg;
    assign triangle.first_index  = out_first_reg;
    assign triangle.second_index = out_second_reg;
    assign triangle.out_of_range = out_oor_reg;
    assign triangle.last         = out_last_reg;

    // A second triangle on a side is only taken where that side matches the core.
    `GFIG_ASSERT_NOW(a_rep_needs_dbl, clk, rst_n, em_valid_reg && rep_reg, em_dbl_reg[side_reg])

    // Within a fan the slot moves by three per triangle.
    `GFIG_ASSERT_NEXT(a_slot_step, clk, rst_n, em_fire && !tri_last && !em_take,
        em_valid_reg && (slot_reg == $past(slot_reg) + gfig_pkg::SLOT_STEP))

    // A newly loaded fan starts on the first triangle of the left side.
    `GFIG_ASSERT_NEXT(a_load_start, clk, rst_n, em_take,
        em_valid_reg && (side_reg == gfig_pkg::SIDE_LEFT) && !rep_reg)

endmodule

// ----- dv/geomip_fan_index_generator_top_tb.sv -----
`timescale 1ns / 1ps

module geomip_fan_index_generator_top_tb;

    localparam int TL_W   = gfig_pkg::TL_W;
    localparam int SLOT_W = gfig_pkg::SLOT_W;
    localparam int LOD_W  = gfig_pkg::LOD_W;
    localparam int XZ_W   = gfig_pkg::XZ_W;
    localparam int IDX_W  = gfig_pkg::IDX_W;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [SLOT_W-1:0] buffer_offset;
        logic [LOD_W-1:0]  lod_core;
        logic [LOD_W-1:0]  lod_left;
        logic [LOD_W-1:0]  lod_right;
        logic [LOD_W-1:0]  lod_top;
        logic [LOD_W-1:0]  lod_bottom;
        logic [XZ_W-1:0]   fan_x;
        logic [XZ_W-1:0]   fan_z;
    } fan_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [IDX_W-1:0]  center_index;
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  second_index;
        logic              out_of_range;
        logic              last;
    } triangle_t;

    // Predicts the triangles of each accepted fan and checks them in order.
    class fan_scoreboard;
        logic [TL_W-1:0] terrain_length;
        triangle_t       expected_tris[$];
        int              errors;

        function new();
            terrain_length = gfig_pkg::TERRAIN_LENGTH_RESET;
            errors = 0;
        endfunction

        function void set_length(logic [TL_W-1:0] value);
            terrain_length = value;
        endfunction

        function int pending();
            return expected_tris.size();
        endfunction

        // Walk the rim: left upward, top rightward, right downward, bottom leftward.
        function void note_fan(fan_t f);
            longint         t;
            longint         lim;
            longint         sc;
            longint         centre;
            longint         a;
            longint         b;
            longint         step;
            logic [LOD_W-1:0] side_lod[4];
            int             total;
            int             k;
            int             count;
            triangle_t      e;

            t = longint'(terrain_length);
            lim = t * t;
            sc = longint'(1) << f.lod_core;
            centre = (longint'(f.fan_z) + sc) * t + longint'(f.fan_x) + sc;
            side_lod[gfig_pkg::SIDE_LEFT]   = f.lod_left;
            side_lod[gfig_pkg::SIDE_TOP]    = f.lod_top;
            side_lod[gfig_pkg::SIDE_RIGHT]  = f.lod_right;
            side_lod[gfig_pkg::SIDE_BOTTOM] = f.lod_bottom;

            total = 0;
            for (int side = 0; side < 4; side++)
            begin
                total += (side_lod[side] == f.lod_core) ? 2 : 1;
            end

            b = longint'(f.fan_z) * t + longint'(f.fan_x);
            k = 0;
            for (int side = 0; side < 4; side++)
            begin
                step = longint'(1) << side_lod[side];
                if (side == gfig_pkg::SIDE_LEFT || side == gfig_pkg::SIDE_RIGHT)
                begin
                    step = step * t;
                end
                if (side == gfig_pkg::SIDE_RIGHT || side == gfig_pkg::SIDE_BOTTOM)
                begin
                    step = -step;
                end
                count = (side_lod[side] == f.lod_core) ? 2 : 1;
                for (int rep = 0; rep < count; rep++)
                begin
                    a = b;
                    b = a + step;
                    e.slot         = f.buffer_offset + gfig_pkg::SLOT_STEP * SLOT_W'(k);
                    e.center_index = IDX_W'(centre);
                    e.first_index  = IDX_W'(a);
                    e.second_index = IDX_W'(b);
                    e.out_of_range = (centre < 0 || centre >= lim || a < 0 || a >= lim ||
                                      b < 0 || b >= lim);
                    e.last         = (k == total - 1);
                    expected_tris.push_back(e);
                    k++;
                end
            end
        endfunction

        function void check_triangle(triangle_t got);
            triangle_t want;
            bit        bad;

            if (expected_tris.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("ERROR: unexpected triangle slot=%h c=%h a=%h b=%h oor=%b last=%b",
                             got.slot, got.center_index, got.first_index, got.second_index,
                             got.out_of_range, got.last);
                end
                return;
            end
            want = expected_tris.pop_front();
            bad = (got.slot !== want.slot) || (got.center_index !== want.center_index) ||
                  (got.first_index !== want.first_index) ||
                  (got.second_index !== want.second_index) ||
                  (got.out_of_range !== want.out_of_range) || (got.last !== want.last);
            if (bad)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("ERROR: expected slot=%h c=%h a=%h b=%h oor=%b last=%b",
                             want.slot, want.center_index, want.first_index,
                             want.second_index, want.out_of_range, want.last);
                    $display("       actual   slot=%h c=%h a=%h b=%h oor=%b last=%b",
                             got.slot, got.center_index, got.first_index,
                             got.second_index, got.out_of_range, got.last);
                end
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [TL_W-1:0] cfg_wdata;

    gfig_fan_if fan_ch();
    gfig_tri_if tri_ch();

    fan_scoreboard sb;
    fan_t          directed_fans[$];
    int            send_idle_pct;
    int            recv_idle_pct;
    int            stalled_cycles;

    geomip_fan_index_generator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fan       (fan_ch),
        .triangle  (tri_ch)
    );

    // Clock generation.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver back-pressure.
    always @(negedge clk)
    begin
        tri_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Transaction monitors and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (fan_ch.valid && fan_ch.ready)
            begin
                sb.note_fan({fan_ch.buffer_offset, fan_ch.lod_core, fan_ch.lod_left,
                             fan_ch.lod_right, fan_ch.lod_top, fan_ch.lod_bottom,
                             fan_ch.fan_x, fan_ch.fan_z});
            end
            if (tri_ch.valid && tri_ch.ready)
            begin
                sb.check_triangle({tri_ch.slot, tri_ch.center_index, tri_ch.first_index,
                                   tri_ch.second_index, tri_ch.out_of_range, tri_ch.last});
            end
            if ((fan_ch.valid && fan_ch.ready) || (tri_ch.valid && tri_ch.ready))
            begin
                stalled_cycles = 0;
            end
            else
            begin
                stalled_cycles++;
                if (stalled_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    function automatic fan_t make_fan(logic [SLOT_W-1:0] offset, int core, int left, int top,
                                      int right, int bottom, int x, int z);
        fan_t f;

        f.buffer_offset = offset;
        f.lod_core      = LOD_W'(core);
        f.lod_left      = LOD_W'(left);
        f.lod_top       = LOD_W'(top);
        f.lod_right     = LOD_W'(right);
        f.lod_bottom    = LOD_W'(bottom);
        f.fan_x         = XZ_W'(x);
        f.fan_z         = XZ_W'(z);
        return f;
    endfunction

    // Mostly fans that sit inside the grid with sides at core or one coarser,
    // the rest arbitrary field values.
    function automatic fan_t random_fan(int len);
        fan_t f;
        int   top_core;
        int   span;
        int   cells;

        if (len >= 3 && $urandom_range(9) < 7)
        begin
            top_core = 0;
            while (top_core < 10 && (4 << top_core) <= len - 1)
            begin
                top_core++;
            end
            f.lod_core   = LOD_W'($urandom_range(top_core));
            span         = 2 << f.lod_core;
            cells        = (len - 1) / span;
            f.fan_x      = XZ_W'($urandom_range(cells - 1) * span);
            f.fan_z      = XZ_W'($urandom_range(cells - 1) * span);
            f.lod_left   = f.lod_core + LOD_W'($urandom_range(1));
            f.lod_top    = f.lod_core + LOD_W'($urandom_range(1));
            f.lod_right  = f.lod_core + LOD_W'($urandom_range(1));
            f.lod_bottom = f.lod_core + LOD_W'($urandom_range(1));
            if ($urandom_range(7) == 0)
            begin
                f.buffer_offset = SLOT_W'(24'hFFFFF0 + $urandom_range(15));
            end
            else
            begin
                f.buffer_offset = SLOT_W'($urandom);
            end
        end
        else
        begin
            f.buffer_offset = SLOT_W'($urandom);
            f.lod_core      = LOD_W'($urandom);
            f.lod_left      = LOD_W'($urandom);
            f.lod_top       = LOD_W'($urandom);
            f.lod_right     = LOD_W'($urandom);
            f.lod_bottom    = LOD_W'($urandom);
            f.fan_x         = XZ_W'($urandom);
            f.fan_z         = XZ_W'($urandom);
        end
        return f;
    endfunction

    // Present one fan after an optional random gap and hold it until accepted.
    task automatic send_fan(fan_t f);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            fan_ch.valid <= 1'b0;
            @(negedge clk);
        end
        fan_ch.valid         <= 1'b1;
        fan_ch.buffer_offset <= f.buffer_offset;
        fan_ch.lod_core      <= f.lod_core;
        fan_ch.lod_left      <= f.lod_left;
        fan_ch.lod_top       <= f.lod_top;
        fan_ch.lod_right     <= f.lod_right;
        fan_ch.lod_bottom    <= f.lod_bottom;
        fan_ch.fan_x         <= f.fan_x;
        fan_ch.fan_z         <= f.fan_z;
        @(posedge clk);
        while (!fan_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Stop sending and wait until every predicted triangle has been seen.
    task automatic close_burst();
        @(negedge clk);
        fan_ch.valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random(int count);
        repeat (count)
        begin
            send_fan(random_fan(int'(sb.terrain_length)));
        end
        close_burst();
    endtask

    task automatic write_length(int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= TL_W'(value);
        @(posedge clk);
        sb.set_length(TL_W'(value));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        fan_ch.valid = 1'b0;
        fan_ch.buffer_offset = '0;
        fan_ch.lod_core = '0;
        fan_ch.lod_left = '0;
        fan_ch.lod_top = '0;
        fan_ch.lod_right = '0;
        fan_ch.lod_bottom = '0;
        fan_ch.fan_x = '0;
        fan_ch.fan_z = '0;
        tri_ch.ready = 1'b0;
        stalled_cycles = 0;
        send_idle_pct = 17;
        recv_idle_pct = 80;

        // Directed fans, all at the reset terrain length of 257.
        directed_fans.push_back(make_fan(24'h000000, 0, 0, 0, 0, 0, 0, 0));
        directed_fans.push_back(make_fan(24'h000003, 0, 1, 1, 1, 1, 0, 0));
        directed_fans.push_back(make_fan(24'h000100, 1, 2, 1, 1, 1, 4, 4));
        directed_fans.push_back(make_fan(24'h000200, 1, 1, 2, 1, 1, 8, 4));
        directed_fans.push_back(make_fan(24'h000300, 1, 1, 1, 2, 1, 4, 8));
        directed_fans.push_back(make_fan(24'h000400, 1, 1, 1, 1, 2, 8, 8));
        directed_fans.push_back(make_fan(24'h000500, 1, 1, 2, 1, 2, 12, 12));
        // Rim walk drops below row zero.
        directed_fans.push_back(make_fan(24'h000600, 0, 0, 0, 3, 0, 0, 0));
        // Rim walk drops below column zero.
        directed_fans.push_back(make_fan(24'h000700, 0, 0, 0, 0, 4, 0, 0));
        // Sides finer than the core, and coarser by more than one.
        directed_fans.push_back(make_fan(24'h000800, 2, 0, 0, 0, 0, 8, 8));
        directed_fans.push_back(make_fan(24'h000900, 0, 3, 3, 3, 3, 16, 16));
        // Patch that exactly fills the grid.
        directed_fans.push_back(make_fan(24'h000A00, 7, 7, 8, 7, 8, 0, 0));
        directed_fans.push_back(make_fan(24'h000B00, 10, 10, 10, 10, 10, 0, 0));
        // Every field at its maximum: large indices and slot wrap.
        directed_fans.push_back(make_fan(24'hFFFFFF, 15, 15, 15, 15, 15, 8191, 8191));
        // Last cell of the grid, slot wrap inside the fan.
        directed_fans.push_back(make_fan(24'hFFFFFE, 0, 0, 0, 0, 0, 255, 255));
        // One row past the grid.
        directed_fans.push_back(make_fan(24'h001000, 0, 0, 0, 0, 0, 255, 256));
        directed_fans.push_back(make_fan(24'h555555, 5, 10, 5, 10, 5, 13'h1555, 13'h0AAA));
        directed_fans.push_back(make_fan(24'hAAAAAA, 10, 5, 10, 5, 10, 13'h0AAA, 13'h1555));
        directed_fans.push_back(make_fan(24'h001100, 15, 15, 15, 15, 15, 0, 0));
        directed_fans.push_back(make_fan(24'h001200, 0, 14, 0, 14, 0, 100, 100));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_fans[i])
        begin
            send_fan(directed_fans[i]);
        end
        close_burst();

        // Smallest grid.
        write_length(3);
        send_random(15);

        send_idle_pct = 80;
        recv_idle_pct = 17;
        write_length(gfig_pkg::MAX_TERRAIN_LENGTH);
        send_random(20);
        // Zero length puts every index out of range.
        write_length(0);
        send_random(10);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_length(8191);
        send_random(15);
        write_length($urandom_range(3, gfig_pkg::MAX_TERRAIN_LENGTH));
        send_random(30);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
